// ===== sv/mklp_pkg.sv =====
// Package for the address lease pool: command and status codes, register
// indexes, and the probe and claim structs passed along the cell chain.
// No dependencies.
package mklp_pkg;

  // Widest entry index supported by the chain (pool depth up to 64).
  localparam int IDX_W = 6;
  localparam int MAC_W = 48;
  localparam int IP_W  = 32;

  // Command codes.
  localparam logic [1:0] CMD_ALLOC    = 2'd0;
  localparam logic [1:0] CMD_VALIDATE = 2'd1;
  localparam logic [1:0] CMD_RELEASE  = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_GRANTED   = 3'd0;
  localparam logic [2:0] ST_EXHAUSTED = 3'd1;
  localparam logic [2:0] ST_CONFIRMED = 3'd2;
  localparam logic [2:0] ST_REJECTED  = 3'd3;
  localparam logic [2:0] ST_RELEASED  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_BASE_IP = 2'd0;
  localparam logic [1:0] REG_IN_USE  = 2'd1;

  // Search token that walks the chain, one cell per cycle while the chain is not stalled.
  typedef struct packed {
    logic             valid;
    logic [1:0]       cmd;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  req;
    logic [IP_W-1:0]  addr;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [IP_W-1:0]  hit_addr;
    logic             free;
    logic [IDX_W-1:0] free_idx;
    logic [IP_W-1:0]  free_addr;
  } probe_t;

  // Broadcast write that claims a free entry for a client.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [MAC_W-1:0] mac;
  } claim_t;

endpackage

// ===== sv/mklp_in_if.sv =====
// Input channel of the lease pool: valid/ready handshake with command,
// client MAC and requested address. Depends on nothing.
interface mklp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [47:0] client_mac;
  logic [31:0] confirm_ip;

  modport source (output valid, command, client_mac, confirm_ip, input ready);
  modport sink (input valid, command, client_mac, confirm_ip, output ready);
endinterface

// ===== sv/mklp_out_if.sv =====
// Result channel of the lease pool: valid/ready handshake with status,
// leased address, entry index and reuse flag. Depends on nothing.
interface mklp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] lease_ip;
  logic [2:0]  lease_index;
  logic        reused;

  modport source (output valid, status, lease_ip, lease_index, reused, input ready);
  modport sink (input valid, status, lease_ip, lease_index, reused, output ready);
endinterface

// ===== sv/mklp_cell.sv =====
// One lease entry of the chain: holds the active flag and owner MAC,
// inspects the passing probe and registers it for the next cell. Uses mklp_pkg.
module mklp_cell
  import mklp_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic [3:0] in_use,
  input  probe_t     probe_i,
  input  claim_t     claim,
  output probe_t     probe_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [6:0]       MY_POS = 7'(INDEX);

  logic             active_r, active_nxt;
  logic             valid_r;
  logic [MAC_W-1:0] mac_r, mac_nxt;
  probe_t           probe_r, probe_nxt;
  logic             in_svc, mac_eq, cand;

  // Match and candidate terms for this entry.
  always_comb begin
    in_svc = {3'b000, in_use} > MY_POS;
    mac_eq = in_svc && active_r && (mac_r == probe_i.mac);
    if (probe_i.cmd == CMD_VALIDATE) begin
      cand = mac_eq && (probe_i.addr == probe_i.req);
    end else begin
      cand = mac_eq;
    end
  end

  // Update the probe with the lowest hit and the lowest free entry.
  always_comb begin
    probe_nxt      = probe_i;
    probe_nxt.addr = probe_i.addr + 32'd1;
    if (cand && !probe_i.hit) begin
      probe_nxt.hit      = 1'b1;
      probe_nxt.hit_idx  = MY_IDX;
      probe_nxt.hit_addr = probe_i.addr;
    end
    if (in_svc && !active_r && !probe_i.free) begin
      probe_nxt.free      = 1'b1;
      probe_nxt.free_idx  = MY_IDX;
      probe_nxt.free_addr = probe_i.addr;
    end
  end

  // Entry state: release clears on a match, a claim writes the owner.
  always_comb begin
    active_nxt = active_r;
    mac_nxt    = mac_r;
    if (advance && probe_i.valid && probe_i.cmd == CMD_RELEASE && mac_eq) begin
      active_nxt = 1'b0;
    end
    if (claim.en && claim.idx == MY_IDX) begin
      active_nxt = 1'b1;
      mac_nxt    = claim.mac;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      if (advance) begin
        valid_r <= probe_i.valid;
      end
    end
  end

  // Payload of the probe and the owner MAC need no reset.
  always_ff @(posedge clk) begin
    mac_r <= mac_nxt;
    if (advance) begin
      probe_r <= probe_nxt;
    end
  end

  // The token's valid bit comes from the register that is reset.
  always_comb begin
    probe_o       = probe_r;
    probe_o.valid = valid_r;
  end

endmodule

// ===== sv/mac_keyed_address_lease_pool_core.sv =====
// Top level of the MAC-keyed address lease pool: configuration registers,
// the chain of mklp_cell entries and the result register.
// Uses mklp_pkg, mklp_in_if, mklp_out_if and mklp_cell.

// Each transaction enters a chain of POOL_ENTRIES cells, one per lease
// entry, and its search token moves one cell per cycle while the chain
// is not stalled. The token passes every cell, also those beyond the
// entries in use, before its result is written to the output register.
// One transaction is in the chain at a time; the next is accepted in the
// cycle after the token leaves, even while the previous result still
// waits in the output register. The token waits at the end of the chain
// only while the output register is full and out_if.ready is low. An
// allocate that claims a free entry writes it as the token leaves the
// chain. Configuration registers must be written only while no
// transaction is in flight.
module mac_keyed_address_lease_pool_core
  import mklp_pkg::*;
#(
  parameter int POOL_ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  mklp_in_if.sink     in_if,
  mklp_out_if.source  out_if,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [IP_W-1:0]   base_r;
  logic [3:0]        in_use_r;
  logic              busy_r, busy_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        status_r, status_nxt;
  logic [IP_W-1:0]   lease_ip_r, lease_ip_nxt;
  logic [2:0]        index_r, index_nxt;
  logic              reused_r, reused_nxt;
  probe_t            probe [POOL_ENTRIES+1];
  logic [POOL_ENTRIES-1:0] tok_valid;
  claim_t            claim;
  probe_t            last;
  logic              advance, accept, leave;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= 32'hC0A8_1B02;
      in_use_r <= 4'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_IP: base_r   <= cfg_wdata;
        REG_IN_USE:  in_use_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Handshake and chain control; the chain stalls only while a finished
  // token waits for the output register.
  assign last          = probe[POOL_ENTRIES];
  assign advance       = !(last.valid && out_valid_r && !out_if.ready);
  assign in_if.ready   = !busy_r;
  assign accept        = in_if.valid && !busy_r;
  assign leave         = last.valid && advance;

  // Token presented to the first cell.
  always_comb begin
    probe[0].valid     = accept;
    probe[0].cmd       = in_if.command;
    probe[0].mac       = in_if.client_mac;
    probe[0].req       = in_if.confirm_ip;
    probe[0].addr      = base_r;
    probe[0].hit       = 1'b0;
    probe[0].hit_idx   = '0;
    probe[0].hit_addr  = '0;
    probe[0].free      = 1'b0;
    probe[0].free_idx  = '0;
    probe[0].free_addr = '0;
  end

  // The chain of entry cells.
  for (genvar g = 0; g < POOL_ENTRIES; g++) begin : g_cell
    mklp_cell #(.INDEX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .in_use  (in_use_r),
      .probe_i (probe[g]),
      .claim   (claim),
      .probe_o (probe[g+1])
    );
    assign tok_valid[g] = probe[g+1].valid;
  end

  // Result decode and the claim of a free entry as the token leaves.
  always_comb begin
    status_nxt   = ST_REJECTED;
    lease_ip_nxt = '0;
    index_nxt    = '0;
    reused_nxt   = 1'b0;
    claim.en     = 1'b0;
    claim.idx    = last.free_idx;
    claim.mac    = last.mac;
    unique case (last.cmd)
      CMD_ALLOC: begin
        if (last.hit) begin
          status_nxt   = ST_GRANTED;
          lease_ip_nxt = last.hit_addr;
          index_nxt    = last.hit_idx[2:0];
          reused_nxt   = 1'b1;
        end else if (last.free) begin
          status_nxt   = ST_GRANTED;
          lease_ip_nxt = last.free_addr;
          index_nxt    = last.free_idx[2:0];
          claim.en     = leave;
        end else begin
          status_nxt = ST_EXHAUSTED;
        end
      end
      CMD_VALIDATE: begin
        if (last.hit) begin
          status_nxt   = ST_CONFIRMED;
          lease_ip_nxt = last.hit_addr;
          index_nxt    = last.hit_idx[2:0];
        end
      end
      CMD_RELEASE: status_nxt = ST_RELEASED;
      default: ;
    endcase
  end

  // Busy flag and result valid.
  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (leave) begin
      busy_nxt = 1'b0;
    end
    if (leave) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (leave) begin
      status_r   <= status_nxt;
      lease_ip_r <= lease_ip_nxt;
      index_r    <= index_nxt;
      reused_r   <= reused_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.status      = status_r;
  assign out_if.lease_ip    = lease_ip_r;
  assign out_if.lease_index = index_r;
  assign out_if.reused      = reused_r;

  // At most one token is ever in the chain.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_valid) <= 1)
    else $error("more than one token in the cell chain");

  // When the block is free to accept, the chain is empty.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (tok_valid == '0))
    else $error("token in chain while input is ready");

  // An accepted transaction keeps the input closed in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r)
    else $error("input not closed after accept");

  // A claim comes only from an allocate without an existing lease.
  a_claim_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    claim.en |-> (last.cmd == CMD_ALLOC && !last.hit && last.free && leave))
    else $error("claim issued outside a fresh allocate");

  // A leaving token always produces a valid result in the next cycle.
  a_leave_out: assert property (@(posedge clk) disable iff (!rst_n)
    leave |=> out_valid_r)
    else $error("result lost after token left the chain");

endmodule
